FILE: hdl/dual_channel_min_max_moving_average_core_macros.svh
// Assertion macros for the dual channel min/max/average core.
// Clock clk_i and active-low reset rst_ni are taken from the enclosing module.
`ifndef DUAL_CHANNEL_MIN_MAX_MOVING_AVERAGE_CORE_MACROS_SVH
`define DUAL_CHANNEL_MIN_MAX_MOVING_AVERAGE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DCMM_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("dcmm assertion failed");

`define DCMM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcmm assertion failed");

`define DCMM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcmm assertion failed");

`else

`define DCMM_ASSERT(name, expr)
`define DCMM_ASSERT_IMPL(name, ante, cons)
`define DCMM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hdl/dcmm_pkg.sv
`timescale 1ns / 1ps

package dcmm_pkg;

  localparam int unsigned WINDOW   = 4;
  localparam int unsigned CHANNELS = 2;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WIN_L    = $clog2(WINDOW);
  localparam int unsigned SUM_W    = SAMPLE_W + WIN_L;
  localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
  localparam int unsigned HIST_N   = WINDOW - 1;

  // floor division by WINDOW: bias to unsigned, multiply by reciprocal, shift
  localparam longint unsigned AVG_OFS = longint'(WINDOW) << (SAMPLE_W - 1);
  localparam int unsigned     MUL_K   = SUM_W + WIN_L;
  localparam int unsigned     MUL_W   = SUM_W + 2;
  localparam longint unsigned DIV_MUL =
    ((longint'(1) << MUL_K) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam int unsigned     PROD_W  = SUM_W + MUL_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] current_sample;
    logic signed [SAMPLE_W-1:0] temp_sample;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] current_min;
    logic signed [SAMPLE_W-1:0] current_max;
    logic signed [SAMPLE_W-1:0] current_avg;
    logic signed [SAMPLE_W-1:0] temp_min;
    logic signed [SAMPLE_W-1:0] temp_max;
    logic signed [SAMPLE_W-1:0] temp_avg;
  } result_t;

endpackage

FILE: hdl/dual_channel_min_max_moving_average_core.sv
// A word accepted at the input passes the input register, then the result
// register, on its way to the output.
// Throughput: one word per cycle unless the output stalls; the window sum is
// a running sum, one add and one constant multiply per channel between registers.
// Reset (async, active low): min at most positive, max at most negative,
// history, running sums and sample count cleared; both stages empty.
`timescale 1ns / 1ps
`include "dual_channel_min_max_moving_average_core_macros.svh"

module dual_channel_min_max_moving_average_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dcmm_pkg::sample_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dcmm_pkg::result_t out_word_o
);
  import dcmm_pkg::*;

  logic    s1_valid_q;
  sample_t s1_q;
  logic    out_valid_q;
  result_t out_q;
  logic    adv;
  logic    fire;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full;

  logic signed [SAMPLE_W-1:0] samp   [CHANNELS];
  logic signed [SAMPLE_W-1:0] min_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] max_q  [CHANNELS];
  logic signed [SAMPLE_W-1:0] min_d  [CHANNELS];
  logic signed [SAMPLE_W-1:0] max_d  [CHANNELS];
  logic signed [SAMPLE_W-1:0] avg    [CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_q [CHANNELS][HIST_N];
  logic signed [SAMPLE_W-1:0] hist_d [CHANNELS][HIST_N];
  logic signed [SUM_W-1:0]    sum_q  [CHANNELS];
  logic signed [SUM_W-1:0]    sum_d  [CHANNELS];

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;

  assign full  = cnt_q >= CNT_W'(WINDOW - 1);
  assign cnt_d = full ? CNT_W'(WINDOW) : cnt_q + CNT_W'(1);

  assign samp[0] = s1_q.current_sample;
  assign samp[1] = s1_q.temp_sample;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic signed [SUM_W-1:0] samp_x;
    logic signed [SUM_W-1:0] old_x;
    logic signed [SUM_W-1:0] sum_all;
    logic [SUM_W-1:0]        biased;
    logic [PROD_W-1:0]       prod;
    logic [SAMPLE_W-1:0]     quo;

    always_comb begin
      samp_x  = {{(SUM_W-SAMPLE_W){samp[c][SAMPLE_W-1]}}, samp[c]};
      old_x   = {{(SUM_W-SAMPLE_W){hist_q[c][0][SAMPLE_W-1]}}, hist_q[c][0]};
      sum_all = sum_q[c] + samp_x;
      biased  = sum_all + AVG_OFS[SUM_W-1:0];
      prod    = PROD_W'(biased) * PROD_W'(DIV_MUL);
      quo     = prod[MUL_K +: SAMPLE_W];
      avg[c]  = full ? {~quo[SAMPLE_W-1], quo[SAMPLE_W-2:0]} : '0;
      sum_d[c] = sum_all - old_x;
      min_d[c] = (samp[c] < min_q[c]) ? samp[c] : min_q[c];
      max_d[c] = (samp[c] > max_q[c]) ? samp[c] : max_q[c];
      for (int i = 0; i < HIST_N - 1; i++) begin
        hist_d[c][i] = hist_q[c][i+1];
      end
      hist_d[c][HIST_N-1] = samp[c];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        min_q[c] <= SAMPLE_MAX;
        max_q[c] <= SAMPLE_MIN;
        sum_q[c] <= '0;
        for (int i = 0; i < HIST_N; i++) begin
          hist_q[c][i] <= '0;
        end
      end else if (fire) begin
        min_q[c]  <= min_d[c];
        max_q[c]  <= max_d[c];
        sum_q[c]  <= sum_d[c];
        hist_q[c] <= hist_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_word_i;
    end
    if (fire) begin
      out_q.current_min <= min_d[0];
      out_q.current_max <= max_d[0];
      out_q.current_avg <= avg[0];
      out_q.temp_min    <= min_d[1];
      out_q.temp_max    <= max_d[1];
      out_q.temp_avg    <= avg[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `DCMM_ASSERT(a_cnt_range, cnt_q <= CNT_W'(WINDOW))
  `DCMM_ASSERT_IMPL(a_min_le_max, cnt_q != '0, min_q[0] <= max_q[0] && min_q[1] <= max_q[1])
  `DCMM_ASSERT_IMPL(a_stall_cause, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  `DCMM_ASSERT_NEXT(a_warm_avg, fire && !full, out_q.current_avg == '0 && out_q.temp_avg == '0)

endmodule
